[design/assert_macros.svh]
// Assertion helpers shared by the RTL. Every check samples on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[design/mi3_pkg.sv]
package mi3_pkg;

    // Element format.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Cofactor, determinant and divider widths.
    localparam int CW        = 2 * DATA_WIDTH;
    localparam int DETW      = 3 * DATA_WIDTH + 2;
    localparam int PLOW      = 2 * DATA_WIDTH + 1;
    localparam int QB        = DATA_WIDTH + 1;
    localparam int MW        = CW + 2 * FRAC_BITS;
    localparam int CMPW      = DETW + QB;
    localparam int DIV_CNT_W = $clog2(QB);

    // Front-to-back queue.
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [CW-1:0]         cof_t;
    typedef logic signed [DETW-1:0]       det_t;

    localparam elem_t ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // One classified matrix: nine cofactors in row order and the determinant.
    typedef struct packed {
        logic [8:0][CW-1:0] cof;
        logic [DETW-1:0]    det;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PREP,
        B_DIV,
        B_DONE
    } back_state_t;

    function automatic int mod3(input int v);
        mod3 = v % 3;
    endfunction

endpackage

[design/mi3_mat_if.sv]
interface mi3_mat_if;
    logic              valid;
    logic              ready;
    mi3_pkg::elem_t    m00;
    mi3_pkg::elem_t    m01;
    mi3_pkg::elem_t    m02;
    mi3_pkg::elem_t    m10;
    mi3_pkg::elem_t    m11;
    mi3_pkg::elem_t    m12;
    mi3_pkg::elem_t    m20;
    mi3_pkg::elem_t    m21;
    mi3_pkg::elem_t    m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

[design/mi3_inv_if.sv]
interface mi3_inv_if;
    logic              valid;
    logic              ready;
    mi3_pkg::elem_t    r00;
    mi3_pkg::elem_t    r01;
    mi3_pkg::elem_t    r02;
    mi3_pkg::elem_t    r10;
    mi3_pkg::elem_t    r11;
    mi3_pkg::elem_t    r12;
    mi3_pkg::elem_t    r20;
    mi3_pkg::elem_t    r21;
    mi3_pkg::elem_t    r22;
    logic              singular;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, output ready);
endinterface

[design/matrix3_inverse_core.sv]
// 3x3 matrix inverse by adjugate and determinant, signed Q16.16 elements.
// The mat channel takes one word per matrix (m00 .. m22, row by row); the inv
// channel returns one word per matrix with the nine inverse elements and the
// singular flag. Both channels move a word when valid and ready are high.
// A five-stage front pipeline forms the cofactors and the determinant and
// accepts a new matrix every cycle while the two-entry queue behind it has room.
// The back end runs nine restoring dividers side by side, one quotient bit per
// cycle; a matrix passes through load, setup, the divide steps and retire, and
// a singular matrix goes from setup straight to retire. The back end takes the
// next matrix only once it has retired the last one.
// Quotients are truncated toward zero and saturate to the Q16.16 range; a zero
// determinant returns all-zero elements with singular set.
// The result sits in an output register, so the dividers keep working on the
// next matrix while the receiver stalls; mat.ready drops when the last front
// stage holds a matrix and the queue is full.
// Reset clears all valid flags and the queue; no result is pending after reset.
`include "assert_macros.svh"

module matrix3_inverse_core (
    input  logic       clk,
    input  logic       rst_n,
    mi3_mat_if.sink    mat,
    mi3_inv_if.source  inv
);

    logic                fq_push;
    logic                fq_pop;
    mi3_pkg::job_t       fq_push_job;
    mi3_pkg::job_t       fq_pop_job;
    mi3_pkg::fifo_stat_t fq_stat;
    mi3_pkg::elem_t      res_any;

    mi3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .mat      (mat),
        .fq_stat  (fq_stat),
        .push     (fq_push),
        .push_job (fq_push_job)
    );

    mi3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .push_job (fq_push_job),
        .pop      (fq_pop),
        .pop_job  (fq_pop_job),
        .stat     (fq_stat)
    );

    mi3_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .fq_stat (fq_stat),
        .job     (fq_pop_job),
        .pop     (fq_pop),
        .inv     (inv)
    );

    // Any set bit among the nine result elements.
    assign res_any = inv.r00 | inv.r01 | inv.r02 | inv.r10 | inv.r11 | inv.r12
                   | inv.r20 | inv.r21 | inv.r22;

    // The front never writes into a full queue and the back never reads an empty one.
    `ASSERT_CLK(a_push_room, fq_push |-> !fq_stat.full, "push into full queue")
    `ASSERT_CLK(a_pop_data, fq_pop |-> !fq_stat.empty, "pop from empty queue")
    // A singular result carries all-zero elements.
    `ASSERT_CLK(a_sing_zero, (inv.valid && inv.singular) |-> (res_any == '0), "singular not zero")

endmodule

[design/mi3_front.sv]
module mi3_front (
    input  logic                clk,
    input  logic                rst_n,
    mi3_mat_if.sink             mat,
    input  mi3_pkg::fifo_stat_t fq_stat,
    output logic                push,
    output mi3_pkg::job_t       push_job
);

    localparam int DW = mi3_pkg::DATA_WIDTH;

    function automatic mi3_pkg::cof_t smul(input mi3_pkg::elem_t a, input mi3_pkg::elem_t b);
        smul = mi3_pkg::cof_t'(a) * mi3_pkg::cof_t'(b);
    endfunction

    mi3_pkg::elem_t m [3][3];

    logic [4:0]              v_reg;
    logic                    adv;

    mi3_pkg::cof_t           t1_reg [9];
    mi3_pkg::cof_t           t2_reg [9];
    mi3_pkg::elem_t          row0_s1_reg [3];
    mi3_pkg::cof_t           cof_s2_reg [9];
    mi3_pkg::elem_t          row0_s2_reg [3];
    logic signed [mi3_pkg::PLOW-1:0] plo_reg [3];
    mi3_pkg::cof_t           phi_reg [3];
    mi3_pkg::cof_t           cof_s3_reg [9];
    mi3_pkg::det_t           term_reg [3];
    mi3_pkg::cof_t           cof_s4_reg [9];
    mi3_pkg::det_t           det_reg;
    mi3_pkg::cof_t           cof_s5_reg [9];

    assign m[0][0] = mat.m00;
    assign m[0][1] = mat.m01;
    assign m[0][2] = mat.m02;
    assign m[1][0] = mat.m10;
    assign m[1][1] = mat.m11;
    assign m[1][2] = mat.m12;
    assign m[2][0] = mat.m20;
    assign m[2][1] = mat.m21;
    assign m[2][2] = mat.m22;

    // The whole pipeline stalls only when its last stage holds a word and the queue is full.
    assign adv       = !(v_reg[4] && fq_stat.full);
    assign mat.ready = adv;
    assign push      = v_reg[4] && !fq_stat.full;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            push_job.cof[k] = cof_s5_reg[k];
        end
        push_job.det = det_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], mat.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: the two products of every cofactor.
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    t1_reg[i*3+j] <= smul(m[mi3_pkg::mod3(i+1)][mi3_pkg::mod3(j+1)],
                                          m[mi3_pkg::mod3(i+2)][mi3_pkg::mod3(j+2)]);
                    t2_reg[i*3+j] <= smul(m[mi3_pkg::mod3(i+1)][mi3_pkg::mod3(j+2)],
                                          m[mi3_pkg::mod3(i+2)][mi3_pkg::mod3(j+1)]);
                end
                row0_s1_reg[i] <= m[0][i];
            end
            // Stage 2: cofactors.
            for (int k = 0; k < 9; k++)
            begin
                cof_s2_reg[k] <= t1_reg[k] - t2_reg[k];
            end
            row0_s2_reg <= row0_s1_reg;
            // Stage 3: first-row terms of the determinant as two partial products.
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= mi3_pkg::PLOW'(row0_s2_reg[j])
                            * $signed({{(mi3_pkg::PLOW-DW){1'b0}}, cof_s2_reg[j][DW-1:0]});
                phi_reg[j] <= mi3_pkg::cof_t'(row0_s2_reg[j])
                            * mi3_pkg::cof_t'($signed(cof_s2_reg[j][mi3_pkg::CW-1:DW]));
            end
            cof_s3_reg <= cof_s2_reg;
            // Stage 4: recombine each term.
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= (mi3_pkg::det_t'(phi_reg[j]) <<< DW)
                             + mi3_pkg::det_t'(plo_reg[j]);
            end
            cof_s4_reg <= cof_s3_reg;
            // Stage 5: determinant.
            det_reg    <= term_reg[0] + term_reg[1] + term_reg[2];
            cof_s5_reg <= cof_s4_reg;
        end
    end

endmodule

[design/mi3_queue.sv]
module mi3_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mi3_pkg::job_t       push_job,
    input  logic                pop,
    output mi3_pkg::job_t       pop_job,
    output mi3_pkg::fifo_stat_t stat
);

    mi3_pkg::job_t                mem [mi3_pkg::FQ_DEPTH];
    logic [mi3_pkg::FQ_AW-1:0]    wr_ptr_reg;
    logic [mi3_pkg::FQ_AW-1:0]    rd_ptr_reg;
    logic [mi3_pkg::FQ_AW:0]      cnt_reg;
    logic [mi3_pkg::FQ_AW:0]      cnt_next;

    assign stat.full  = (cnt_reg == (mi3_pkg::FQ_AW+1)'(mi3_pkg::FQ_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_job    = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[design/mi3_back.sv]
module mi3_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mi3_pkg::fifo_stat_t fq_stat,
    input  mi3_pkg::job_t       job,
    output logic                pop,
    mi3_inv_if.source           inv
);

    localparam int DW = mi3_pkg::DATA_WIDTH;
    localparam logic [mi3_pkg::QB-1:0] LIM_Q = mi3_pkg::QB'(1) << (DW-1);

    function automatic mi3_pkg::elem_t sat(input logic [mi3_pkg::QB-1:0] q,
                                           input logic hi, input logic neg);
        mi3_pkg::elem_t r;
        if (hi)
        begin
            r = neg ? mi3_pkg::ELEM_MIN : mi3_pkg::ELEM_MAX;
        end
        else if (neg)
        begin
            r = (q > LIM_Q) ? mi3_pkg::ELEM_MIN : mi3_pkg::elem_t'(mi3_pkg::QB'(0) - q);
        end
        else
        begin
            r = (q > LIM_Q - 1'b1) ? mi3_pkg::ELEM_MAX : q[DW-1:0];
        end
        sat = r;
    endfunction

    mi3_pkg::back_state_t         state_reg;
    mi3_pkg::back_state_t         state_next;
    logic [mi3_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          load_job;
    logic                          load_out;
    logic                          out_free;
    logic                          div_last;

    logic [mi3_pkg::DETW-1:0]     ad_reg;
    logic                          sing_reg;
    logic [mi3_pkg::CW-1:0]       an_reg [9];
    logic                          neg_reg [9];
    logic                          hi_reg [9];
    logic [mi3_pkg::DETW-1:0]     rem_reg [9];
    logic [mi3_pkg::QB-1:0]       nl_reg [9];
    logic [mi3_pkg::QB-1:0]       q_reg [9];

    logic                          ov_reg;
    logic                          osing_reg;
    mi3_pkg::elem_t                res_reg [9];

    assign out_free = !ov_reg || inv.ready;
    assign div_last = (cnt_reg == mi3_pkg::DIV_CNT_W'(mi3_pkg::QB-1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mi3_pkg::B_IDLE:
            begin
                if (!fq_stat.empty)
                begin
                    state_next = mi3_pkg::B_PREP;
                end
            end
            mi3_pkg::B_PREP:
            begin
                state_next = sing_reg ? mi3_pkg::B_DONE : mi3_pkg::B_DIV;
            end
            mi3_pkg::B_DIV:
            begin
                if (div_last)
                begin
                    state_next = mi3_pkg::B_DONE;
                end
            end
            mi3_pkg::B_DONE:
            begin
                if (out_free)
                begin
                    state_next = mi3_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = mi3_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load_job = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            mi3_pkg::B_IDLE: load_job = !fq_stat.empty;
            mi3_pkg::B_DONE: load_out = out_free;
            default:
            begin
                load_job = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign pop = load_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mi3_pkg::B_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mi3_pkg::B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (inv.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [mi3_pkg::MW-1:0]   mag;
        logic [mi3_pkg::DETW:0]   rs;
        mi3_pkg::cof_t            c;
        mi3_pkg::det_t            d;
        if (load_job)
        begin
            d        = $signed(job.det);
            ad_reg   <= d[mi3_pkg::DETW-1] ? mi3_pkg::DETW'(-d) : mi3_pkg::DETW'(d);
            sing_reg <= (d == '0);
            // Lane i*3+j takes the transposed cofactor.
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    c = $signed(job.cof[j*3+i]);
                    an_reg[i*3+j]  <= c[mi3_pkg::CW-1] ? mi3_pkg::CW'(-c) : mi3_pkg::CW'(c);
                    neg_reg[i*3+j] <= c[mi3_pkg::CW-1] ^ d[mi3_pkg::DETW-1];
                end
            end
        end
        if (state_reg == mi3_pkg::B_PREP)
        begin
            for (int k = 0; k < 9; k++)
            begin
                mag        = mi3_pkg::MW'(an_reg[k]) << (2 * mi3_pkg::FRAC_BITS);
                hi_reg[k]  <= (mi3_pkg::CMPW'(mag) >= {ad_reg, {mi3_pkg::QB{1'b0}}});
                rem_reg[k] <= mi3_pkg::DETW'(mag >> mi3_pkg::QB);
                nl_reg[k]  <= mag[mi3_pkg::QB-1:0];
                q_reg[k]   <= '0;
            end
        end
        if (state_reg == mi3_pkg::B_DIV)
        begin
            // One restoring step per lane per cycle.
            for (int k = 0; k < 9; k++)
            begin
                rs = {rem_reg[k], nl_reg[k][mi3_pkg::QB-1]};
                if (rs >= {1'b0, ad_reg})
                begin
                    rem_reg[k] <= mi3_pkg::DETW'(rs - {1'b0, ad_reg});
                    q_reg[k]   <= {q_reg[k][mi3_pkg::QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= mi3_pkg::DETW'(rs);
                    q_reg[k]   <= {q_reg[k][mi3_pkg::QB-2:0], 1'b0};
                end
                nl_reg[k] <= {nl_reg[k][mi3_pkg::QB-2:0], 1'b0};
            end
        end
        if (load_out)
        begin
            osing_reg <= sing_reg;
            for (int k = 0; k < 9; k++)
            begin
                res_reg[k] <= sing_reg ? '0 : sat(q_reg[k], hi_reg[k], neg_reg[k]);
            end
        end
    end

    assign inv.valid    = ov_reg;
    assign inv.singular = osing_reg;
    assign inv.r00      = res_reg[0];
    assign inv.r01      = res_reg[1];
    assign inv.r02      = res_reg[2];
    assign inv.r10      = res_reg[3];
    assign inv.r11      = res_reg[4];
    assign inv.r12      = res_reg[5];
    assign inv.r20      = res_reg[6];
    assign inv.r21      = res_reg[7];
    assign inv.r22      = res_reg[8];

endmodule

[dv/matrix3_inverse_core_test.sv]
`timescale 1ns / 1ps

module matrix3_inverse_core_test;

    // One inverse word as the block returns it: nine elements in row order plus the flag.
    typedef struct {
        mi3_pkg::elem_t r [9];
        logic           sing;
    } inv_word_t;

    // One row of the directed table. When known is set, the expected inverse is
    // typed in by hand instead of being worked out by the predictor.
    typedef struct {
        mi3_pkg::elem_t m [9];
        bit             known;
        inv_word_t      want;
    } matrix_row_t;

    localparam int  NUM_RANDOM  = 930;
    localparam int  WATCHDOG    = 3000;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  STALL_LEN   = 400;
    localparam mi3_pkg::elem_t ONE = mi3_pkg::elem_t'(1 << mi3_pkg::FRAC_BITS);

    logic clk;
    logic rst_n;

    mi3_mat_if mat_ch ();
    mi3_inv_if inv_ch ();

    matrix3_inverse_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat_ch),
        .inv   (inv_ch)
    );

    // Inverses still owed by the block, oldest first.
    inv_word_t   pending_inverses [$];
    matrix_row_t directed_rows [$];
    int          mismatches;
    int          words_checked;
    int          idle_cycles;
    bit          calm;            // while set, neither side idles
    bit          hold_request;    // asks the receiver for one long hold-off
    bit          stim_done;

    always #5 clk = ~clk;

    // Predictor: exact cofactors and determinant in wide signed arithmetic, then a
    // truncating divide of each adjugate entry scaled by 2^(2*FRAC_BITS), saturated.
    function automatic inv_word_t invert_matrix(input mi3_pkg::elem_t m [9]);
        logic signed [127:0] a [9];
        logic signed [127:0] cof [9];
        logic signed [127:0] det;
        logic signed [127:0] num;
        logic signed [127:0] q;
        inv_word_t res;
        int r1, r2, c1, c2;
        for (int k = 0; k < 9; k++)
            a[k] = m[k];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                r1 = (i + 1) % 3;
                r2 = (i + 2) % 3;
                c1 = (j + 1) % 3;
                c2 = (j + 2) % 3;
                cof[i*3+j] = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
            end
        det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
        res.sing = (det == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                if (res.sing)
                begin
                    res.r[i*3+j] = '0;
                end
                else
                begin
                    num = cof[j*3+i] <<< (2 * mi3_pkg::FRAC_BITS);
                    q   = num / det;
                    if (q > 128'sd2147483647)
                        res.r[i*3+j] = mi3_pkg::ELEM_MAX;
                    else if (q < -128'sd2147483648)
                        res.r[i*3+j] = mi3_pkg::ELEM_MIN;
                    else
                        res.r[i*3+j] = mi3_pkg::elem_t'(q);
                end
            end
        return res;
    endfunction

    task automatic report(input string what, input int idx, input int got, input int want);
        $display("ERROR word %0d %s: got %h expected %h", idx, what, got, want);
        mismatches++;
    endtask

    function automatic mi3_pkg::elem_t small_value();
        // Within about +/-4.0 so that most inverses stay in range.
        return mi3_pkg::elem_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic mi3_pkg::elem_t any_value();
        case ($urandom_range(0, 5))
            0:       return mi3_pkg::ELEM_MAX;
            1:       return mi3_pkg::ELEM_MIN;
            2:       return '0;
            default: return mi3_pkg::elem_t'($urandom);
        endcase
    endfunction

    // Random matrix of a randomly chosen flavor; a share of them are singular on purpose.
    task automatic make_random(output mi3_pkg::elem_t m [9]);
        int kind;
        int sel;
        bit dup;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++)
            m[k] = (kind < 4) ? small_value()
                 : (kind < 6) ? mi3_pkg::elem_t'($urandom) : any_value();
        if (kind == 8)
        begin
            // Two equal rows or one zero row give a zero determinant.
            sel = $urandom_range(0, 2);
            dup = $urandom_range(0, 1);
            for (int c = 0; c < 3; c++)
                m[((sel + 1) % 3)*3+c] = dup ? m[sel*3+c] : mi3_pkg::elem_t'(0);
        end
        else if (kind == 9)
        begin
            // Diagonal matrix with pivots from any_value: extremes, zeros and random words.
            for (int k = 0; k < 9; k++)
                if (k % 4 != 0)
                    m[k] = '0;
        end
    endtask

    function automatic matrix_row_t row(input mi3_pkg::elem_t d0, d1, d2, d3, d4, d5, d6,
                                        d7, d8);
        matrix_row_t t;
        t.m = '{d0, d1, d2, d3, d4, d5, d6, d7, d8};
        t.known = 0;
        return t;
    endfunction

    function automatic matrix_row_t known_row(input matrix_row_t t, input mi3_pkg::elem_t dg,
                                              input mi3_pkg::elem_t off, input logic sing);
        for (int k = 0; k < 9; k++)
            t.want.r[k] = (k % 4 == 0) ? dg : off;
        t.want.sing = sing;
        t.known = 1;
        return t;
    endfunction

    task automatic build_directed();
        mi3_pkg::elem_t mx;
        mi3_pkg::elem_t mn;
        mx = mi3_pkg::ELEM_MAX;
        mn = mi3_pkg::ELEM_MIN;
        // The identity and twice the identity invert to themselves and to one half.
        directed_rows.push_back(known_row(row(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), ONE, 0, 0));
        directed_rows.push_back(known_row(row(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE),
                                          ONE / 2, 0, 0));
        // Zero, all-maximum and all-minimum matrices have rank at most one: singular.
        directed_rows.push_back(known_row(row(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 1));
        directed_rows.push_back(known_row(row(mx, mx, mx, mx, mx, mx, mx, mx, mx), 0, 0, 1));
        directed_rows.push_back(known_row(row(mn, mn, mn, mn, mn, mn, mn, mn, mn), 0, 0, 1));
        // A diagonal of one LSB inverts to 2^32 in Q16.16 and saturates high;
        // minus one LSB saturates low.
        directed_rows.push_back(known_row(row(1, 0, 0, 0, 1, 0, 0, 0, 1), mx, 0, 0));
        directed_rows.push_back(known_row(row(-1, 0, 0, 0, -1, 0, 0, 0, -1), mn, 0, 0));
        // The rest are checked by the predictor.
        directed_rows.push_back(row(mx, 0, 0, 0, mx, 0, 0, 0, mx));
        directed_rows.push_back(row(mn, 0, 0, 0, mn, 0, 0, 0, mn));
        directed_rows.push_back(row(mn, mx, 0, mx, mn, 0, 0, 0, ONE));
        directed_rows.push_back(row(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
        directed_rows.push_back(row(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0));
        directed_rows.push_back(row(-ONE, ONE/2, 0, 3*ONE, -2*ONE, ONE/4, ONE, ONE, -ONE));
        directed_rows.push_back(row(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE,
                                    9*ONE));
        directed_rows.push_back(row(mx, mn, mx, mn, mx, mn, mx, mn, mn));
        directed_rows.push_back(row(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        directed_rows.push_back(row(3, 0, 1, 0, 5, 0, 1, 0, 7));
    endtask

    // Offers one matrix word and waits for it to be accepted. The handshake is
    // sampled at the falling edge, half a period away from any driven change.
    // Valid stays high after acceptance; the next call or the caller lowers it.
    task automatic send_matrix(input mi3_pkg::elem_t m [9], input bit known,
                               input inv_word_t want);
        bit taken;
        while (!calm && $urandom_range(0, 99) < 28)
        begin
            mat_ch.valid <= 1'b0;
            @(posedge clk);
        end
        mat_ch.valid <= 1'b1;
        mat_ch.m00 <= m[0]; mat_ch.m01 <= m[1]; mat_ch.m02 <= m[2];
        mat_ch.m10 <= m[3]; mat_ch.m11 <= m[4]; mat_ch.m12 <= m[5];
        mat_ch.m20 <= m[6]; mat_ch.m21 <= m[7]; mat_ch.m22 <= m[8];
        do
        begin
            @(negedge clk);
            taken = mat_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        pending_inverses.push_back(known ? want : invert_matrix(m));
    endtask

    // Stimulus.
    initial
    begin
        mi3_pkg::elem_t m [9];
        inv_word_t      none;
        clk          = 1'b0;
        rst_n        = 1'b0;
        mismatches   = 0;
        calm         = 0;
        hold_request = 0;
        stim_done    = 0;
        mat_ch.valid <= 1'b0;
        mat_ch.m00 <= '0; mat_ch.m01 <= '0; mat_ch.m02 <= '0;
        mat_ch.m10 <= '0; mat_ch.m11 <= '0; mat_ch.m12 <= '0;
        mat_ch.m20 <= '0; mat_ch.m21 <= '0; mat_ch.m22 <= '0;
        none.sing = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        foreach (directed_rows[i])
            send_matrix(directed_rows[i].m, directed_rows[i].known, directed_rows[i].want);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // A stretch with no idling on either side.
            if (n == 300)
                calm = 1;
            if (n == 450)
                calm = 0;
            // Long receiver hold-off while words keep coming, so the block backs up.
            if (n == 550)
                hold_request = 1;
            // The sender goes quiet until every inverse has come back.
            if (n == 700)
            begin
                mat_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending_inverses.size() != 0)
                    @(posedge clk);
            end
            make_random(m);
            send_matrix(m, 0, none);
        end
        mat_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    initial
    begin
        int hold_left;
        hold_left = 0;
        inv_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_request = 0;
                hold_left    = STALL_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                inv_ch.ready <= 1'b0;
            end
            else
            begin
                inv_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // Checker and watchdog, sampled at the falling edge. A word seen with valid and
    // ready here is the one that moves at the coming rising edge.
    always @(negedge clk)
    begin
        inv_word_t      want;
        mi3_pkg::elem_t got [9];
        if (rst_n)
        begin
            if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (inv_ch.valid && inv_ch.ready)
            begin
                got = '{inv_ch.r00, inv_ch.r01, inv_ch.r02, inv_ch.r10, inv_ch.r11,
                        inv_ch.r12, inv_ch.r20, inv_ch.r21, inv_ch.r22};
                if (pending_inverses.size() == 0)
                begin
                    report("unexpected", words_checked, 0, 0);
                end
                else
                begin
                    want = pending_inverses.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want.r[k])
                            report($sformatf("r%0d%0d", k / 3, k % 3), words_checked,
                                   got[k], want.r[k]);
                    if (inv_ch.singular !== want.sing)
                        report("singular", words_checked, inv_ch.singular, want.sing);
                end
                words_checked++;
            end
        end
        else
        begin
            idle_cycles   = 0;
            words_checked = 0;
        end
    end

    // End of run: all words sent, all inverses back, then the drain wait.
    initial
    begin
        wait (stim_done);
        while (pending_inverses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_inverses.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/mi3_pkg.sv
design/mi3_mat_if.sv
design/mi3_inv_if.sv
design/mi3_front.sv
design/mi3_queue.sv
design/mi3_back.sv
design/matrix3_inverse_core.sv
dv/matrix3_inverse_core_test.sv
